// ===== hdl/atm_pkg.sv =====
// Shared types, codes and reply words for the AT response line matcher.
package atm_pkg;

  // Default line buffer size, one more than the number of characters kept.
  localparam int unsigned LINE_CHARS_DEF = 20;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Match mode register codes.
  localparam logic [1:0] MODE_GENERAL = 2'd0;
  localparam logic [1:0] MODE_CONNECT = 2'd1;
  localparam logic [1:0] MODE_PROMPT  = 2'd2;

  // Verdict codes.
  localparam logic [1:0] V_SUCCESS = 2'd0;
  localparam logic [1:0] V_ERROR   = 2'd1;
  localparam logic [1:0] V_TIMEOUT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MATCH_MODE = 1'b0;
  localparam logic REG_TIMEOUT    = 1'b1;

  // Special bytes.
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Reset value of the timeout register.
  localparam logic [7:0] TIMEOUT_RST = 8'd2;

  // Reply words are held right-aligned: byte 0 is the last character.
  localparam int unsigned WORD_MAX = 17;
  localparam int unsigned WLEN_W   = 5;
  typedef logic [WORD_MAX-1:0][7:0] word_t;

  localparam word_t W_OK      = "OK";
  localparam word_t W_SEND_OK = "SEND OK";
  localparam word_t W_ERROR   = "ERROR";
  localparam word_t W_FAIL    = "FAIL";
  localparam word_t W_ALREADY = "ALREADY CONNECTED";
  localparam word_t W_CLOSED  = "CLOSED";
  localparam word_t W_CONNECT = "CONNECT";

  localparam logic [WLEN_W-1:0] L_OK      = 5'd2;
  localparam logic [WLEN_W-1:0] L_SEND_OK = 5'd7;
  localparam logic [WLEN_W-1:0] L_ERROR   = 5'd5;
  localparam logic [WLEN_W-1:0] L_FAIL    = 5'd4;
  localparam logic [WLEN_W-1:0] L_ALREADY = 5'd17;
  localparam logic [WLEN_W-1:0] L_CLOSED  = 5'd6;
  localparam logic [WLEN_W-1:0] L_CONNECT = 5'd7;

endpackage

// ===== hdl/atm_channels.sv =====
// Valid/ready channel interfaces for the input, result and configuration requests.
interface atm_in_if import atm_pkg::*; (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface atm_out_if import atm_pkg::*; (input logic clk);
  logic       valid;
  logic       ready;
  logic       finished;
  logic [1:0] verdict;
  logic       armed;

  modport source (output valid, output finished, output verdict, output armed, input ready);
  modport sink (input valid, input finished, input verdict, input armed, output ready);
endinterface

interface atm_cfg_if import atm_pkg::*; (input logic clk);
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/at_response_line_matcher_top.sv =====
// Top level of the AT response line matcher.
//
// The matcher follows the bytes a text-command modem sends back and decides
// the outcome of one command. Requests arrive on in_ch: a start request arms
// the matcher, a byte request adds a received byte to the current line (a
// carriage return or line feed ends and checks it), and a tick request counts
// one second toward the timeout. Every request gives exactly one result on
// out_ch: finished, verdict (success, error reply or timeout) and armed.
// cfg_ch writes the match mode and timeout registers; it is always ready. The
// user must write it only while the block is idle; it does not enforce this.
//
// Each request is handled in the cycle it is accepted; its result goes to the
// result register, or to the skid register while out_ch stalls. One request is
// taken every cycle while in_ch.ready is high. A two-entry output stage (result
// register plus skid register) keeps the input open while one result waits;
// in_ch.ready falls only when both are full, i.e. once a stalled result has
// another behind it. Reset clears the armed flag, line length, seconds count
// and both output entries, and sets mode to general and timeout to two seconds.
// The line buffer itself is not cleared; only entries below the length are read.
module at_response_line_matcher_top import atm_pkg::*; #(
  parameter int unsigned LINE_CHARS = LINE_CHARS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  atm_in_if.sink   in_ch,
  atm_out_if.source out_ch,
  atm_cfg_if.sink  cfg_ch
);

  localparam int unsigned KEEP  = LINE_CHARS - 1;
  localparam int unsigned LEN_W = $clog2(KEEP + 1);
  localparam int unsigned IDX_W = $clog2(KEEP);

  // Compare the kept line, cut at its first zero byte, with one reply word.
  function automatic logic line_is(input word_t w, input logic [WLEN_W-1:0] wl,
                                   input logic [KEEP-1:0][7:0] chars,
                                   input logic [LEN_W-1:0] len);
    logic ok;
    int   j;
    ok = 1'b1;
    for (int i = 0; i < int'(WORD_MAX); i++) begin
      j = int'(wl) - 1 - i;
      if (i < int'(wl)) begin
        if (!(i < int'(len))) begin
          ok = 1'b0;
        end else if (chars[i] != w[j[WLEN_W-1:0]]) begin
          ok = 1'b0;
        end
      end
    end
    if ((int'(wl) < int'(len)) && (int'(wl) < int'(KEEP))) begin
      if (chars[IDX_W'(wl)] != CH_NUL) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Configuration registers.
  logic [1:0] match_mode_r;
  logic [7:0] timeout_secs_r;

  // Matcher state.
  logic [KEEP-1:0][7:0] line_chars_r;
  logic [LEN_W-1:0]     line_length_r, line_length_nxt;
  logic [7:0]           seconds_seen_r, seconds_seen_nxt;
  logic                 waiting_r, waiting_nxt;

  // Output stage.
  logic       out_valid_r, skid_valid_r;
  logic       out_fin_r, skid_fin_r;
  logic [1:0] out_verdict_r, skid_verdict_r;
  logic       out_armed_r, skid_armed_r;

  logic       in_acc;
  logic       out_free;
  logic       wr_en;
  logic       res_fin;
  logic [1:0] res_verdict;
  logic [7:0] secs_inc;
  logic       is_connect_ok, is_general_ok, is_general_err;

  assign in_ch.ready  = !skid_valid_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Reply word matches on the current line.
  assign is_connect_ok = line_is(W_CONNECT, L_CONNECT, line_chars_r, line_length_r) ||
                         line_is(W_OK, L_OK, line_chars_r, line_length_r) ||
                         line_is(W_ALREADY, L_ALREADY, line_chars_r, line_length_r);
  assign is_general_ok = line_is(W_OK, L_OK, line_chars_r, line_length_r) ||
                         line_is(W_SEND_OK, L_SEND_OK, line_chars_r, line_length_r);
  assign is_general_err = line_is(W_ERROR, L_ERROR, line_chars_r, line_length_r) ||
                          line_is(W_FAIL, L_FAIL, line_chars_r, line_length_r) ||
                          line_is(W_ALREADY, L_ALREADY, line_chars_r, line_length_r) ||
                          line_is(W_CLOSED, L_CLOSED, line_chars_r, line_length_r);

  // Saturating seconds count for a tick.
  assign secs_inc = (seconds_seen_r != 8'hFF) ? seconds_seen_r + 8'd1 : seconds_seen_r;

  // Next state and result for the request at the input.
  always_comb begin
    line_length_nxt  = line_length_r;
    seconds_seen_nxt = seconds_seen_r;
    waiting_nxt      = waiting_r;
    wr_en            = 1'b0;
    res_fin          = 1'b0;
    res_verdict      = V_SUCCESS;
    case (in_ch.op)
      OP_START: begin
        waiting_nxt      = 1'b1;
        line_length_nxt  = '0;
        seconds_seen_nxt = '0;
        if (timeout_secs_r == 8'd0) begin
          waiting_nxt = 1'b0;
          res_fin     = 1'b1;
          res_verdict = V_TIMEOUT;
        end
      end
      OP_BYTE: begin
        if (waiting_r) begin
          if (match_mode_r == MODE_PROMPT) begin
            if (in_ch.rx_byte == CH_PROMPT) begin
              waiting_nxt = 1'b0;
              res_fin     = 1'b1;
              res_verdict = V_SUCCESS;
            end
          end else if (in_ch.rx_byte == CH_CR || in_ch.rx_byte == CH_LF) begin
            if (line_length_r != '0) begin
              if (match_mode_r == MODE_CONNECT) begin
                if (is_connect_ok) begin
                  res_fin     = 1'b1;
                  res_verdict = V_SUCCESS;
                end
              end else if (is_general_ok) begin
                res_fin     = 1'b1;
                res_verdict = V_SUCCESS;
              end else if (is_general_err) begin
                res_fin     = 1'b1;
                res_verdict = V_ERROR;
              end
            end
            line_length_nxt = '0;
            if (res_fin) begin
              waiting_nxt = 1'b0;
            end
          end else if (line_length_r < LEN_W'(KEEP)) begin
            wr_en           = 1'b1;
            line_length_nxt = line_length_r + 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (waiting_r) begin
          seconds_seen_nxt = secs_inc;
          if (secs_inc >= timeout_secs_r) begin
            waiting_nxt = 1'b0;
            res_fin     = 1'b1;
            res_verdict = V_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_mode_r   <= MODE_GENERAL;
      timeout_secs_r <= TIMEOUT_RST;
      line_length_r  <= '0;
      seconds_seen_r <= '0;
      waiting_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MATCH_MODE: match_mode_r   <= cfg_ch.data[1:0];
          REG_TIMEOUT:    timeout_secs_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        line_length_r  <= line_length_nxt;
        seconds_seen_r <= seconds_seen_nxt;
        waiting_r      <= waiting_nxt;
      end
    end
  end

  // Line buffer write.
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      line_chars_r[line_length_r[IDX_W-1:0]] <= in_ch.rx_byte;
    end
  end

  // Output stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_fin_r     <= skid_fin_r;
        out_verdict_r <= skid_verdict_r;
        out_armed_r   <= skid_armed_r;
      end else if (in_acc) begin
        out_fin_r     <= res_fin;
        out_verdict_r <= res_verdict;
        out_armed_r   <= waiting_nxt;
      end
    end else if (in_acc) begin
      skid_fin_r     <= res_fin;
      skid_verdict_r <= res_verdict;
      skid_armed_r   <= waiting_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.finished = out_fin_r;
  assign out_ch.verdict  = out_verdict_r;
  assign out_ch.armed    = out_armed_r;

endmodule

// ===== hdl/atm_checker.sv =====
// Port-level checks on the matcher's result channel, bound to the top level.
module atm_checker import atm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_finished,
  input logic [1:0] out_verdict,
  input logic       out_armed
);

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_finished) &&
    $stable(out_verdict) && $stable(out_armed))
    else $error("result changed while stalled");

  // A final verdict always disarms the matcher.
  a_fin_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_armed)
    else $error("finished result still armed");

  // Without a verdict the verdict field reads as success.
  a_no_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_verdict == V_SUCCESS)
    else $error("verdict set without finish");

  // Verdict codes stay within the defined set.
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict == V_SUCCESS || out_verdict == V_ERROR ||
    out_verdict == V_TIMEOUT)
    else $error("undefined verdict code");

endmodule

bind at_response_line_matcher_top atm_checker u_atm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_finished (out_ch.finished),
  .out_verdict  (out_ch.verdict),
  .out_armed    (out_ch.armed)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the AT response line matcher: random and directed requests.
module testbench;
  import atm_pkg::*;

  // The op field is two bits wide; code 3 has no meaning and must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int KEEP_CHARS = LINE_CHARS_DEF - 1;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic       finished;
    logic [1:0] verdict;
    logic       armed;
  } outcome_t;

  logic clk;
  logic rst_n = 1'b0;

  // Driven values for every input of the block, known from time zero.
  logic       in_valid = 1'b0;
  logic [1:0] in_op = OP_START;
  logic [7:0] in_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_index = REG_MATCH_MODE;
  logic [7:0] cfg_data = 8'h00;

  atm_in_if  in_ch (clk);
  atm_out_if out_ch (clk);
  atm_cfg_if cfg_ch (clk);

  assign in_ch.valid   = in_valid;
  assign in_ch.op      = in_op;
  assign in_ch.rx_byte = in_byte;
  assign out_ch.ready  = out_ready;
  assign cfg_ch.valid  = cfg_valid;
  assign cfg_ch.index  = cfg_index;
  assign cfg_ch.data   = cfg_data;

  at_response_line_matcher_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Requests waiting to be sent and outcomes waiting to be received.
  req_t     reqs_to_send[$];
  outcome_t outcomes_owed[$];
  int       queued_count = 0;
  int       mismatches = 0;
  int       results_seen = 0;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;

  // Shadow copy of the matcher's registers and state.
  logic [1:0] sh_mode = MODE_GENERAL;
  logic [7:0] sh_timeout = TIMEOUT_RST;
  logic [7:0] sh_line [KEEP_CHARS];
  int         sh_len = 0;
  logic [7:0] sh_secs = 8'd0;
  logic       sh_armed = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous watchdog; a healthy run ends long before this.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
    end
    mismatches++;
  endtask

  // True when the kept line, cut at its first zero byte, spells the word.
  function automatic bit line_spells(input string w);
    int i;
    for (i = 0; i < w.len(); i++) begin
      if (i >= sh_len || i >= KEEP_CHARS) return 1'b0;
      if (sh_line[i] != w[i]) return 1'b0;
    end
    return (i >= sh_len) || (i >= KEEP_CHARS) || (sh_line[i] == CH_NUL);
  endfunction

  // Works out the outcome of one accepted request and advances the shadow state.
  function automatic outcome_t judge_request(input req_t r);
    outcome_t o;
    o = '0;
    if (r.op == OP_START) begin
      sh_armed = 1'b1;
      sh_len = 0;
      sh_secs = 8'd0;
      if (sh_timeout == 8'd0) begin
        sh_armed = 1'b0;
        o.finished = 1'b1;
        o.verdict = V_TIMEOUT;
      end
    end else if (r.op == OP_BYTE && sh_armed) begin
      if (sh_mode == MODE_PROMPT) begin
        if (r.rx_byte == CH_PROMPT) begin
          sh_armed = 1'b0;
          o.finished = 1'b1;
          o.verdict = V_SUCCESS;
        end
      end else if (r.rx_byte == CH_CR || r.rx_byte == CH_LF) begin
        if (sh_len != 0) begin
          if (sh_mode == MODE_CONNECT) begin
            if (line_spells("CONNECT") || line_spells("OK") ||
                line_spells("ALREADY CONNECTED")) begin
              o.finished = 1'b1;
              o.verdict = V_SUCCESS;
            end
          end else if (line_spells("OK") || line_spells("SEND OK")) begin
            o.finished = 1'b1;
            o.verdict = V_SUCCESS;
          end else if (line_spells("ERROR") || line_spells("FAIL") ||
                       line_spells("ALREADY CONNECTED") || line_spells("CLOSED")) begin
            o.finished = 1'b1;
            o.verdict = V_ERROR;
          end
        end
        sh_len = 0;
        if (o.finished) sh_armed = 1'b0;
      end else if (sh_len < KEEP_CHARS) begin
        sh_line[sh_len] = r.rx_byte;
        sh_len++;
      end
    end else if (r.op == OP_TICK && sh_armed) begin
      if (sh_secs != 8'hFF) sh_secs++;
      if (sh_secs >= sh_timeout) begin
        sh_armed = 1'b0;
        o.finished = 1'b1;
        o.verdict = V_TIMEOUT;
      end
    end
    o.armed = sh_armed;
    return o;
  endfunction

  // Request driver: presents queued requests, with random gaps between them.
  always @(posedge clk) begin : feed_requests
    req_t sent;
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ch.ready;
      if (took) begin
        sent = reqs_to_send.pop_front();
        outcomes_owed.push_back(judge_request(sent));
      end
      if (!in_valid || took) begin
        if (reqs_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_op <= reqs_to_send[0].op;
          in_byte <= reqs_to_send[0].rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest outcome owed.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ready) begin
        if (outcomes_owed.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = outcomes_owed.pop_front();
          if (out_ch.finished !== want.finished)
            flag_mismatch($sformatf("finished %b, expected %b", out_ch.finished,
                                    want.finished));
          if (out_ch.verdict !== want.verdict)
            flag_mismatch($sformatf("verdict %0d, expected %0d", out_ch.verdict,
                                    want.verdict));
          if (out_ch.armed !== want.armed)
            flag_mismatch($sformatf("armed %b, expected %b", out_ch.armed, want.armed));
        end
        results_seen++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(input logic [1:0] op, input logic [7:0] b);
    req_t r;
    r.op = op;
    r.rx_byte = b;
    reqs_to_send.push_back(r);
    queued_count++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_req(OP_BYTE, b);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic string reply_word(input int k);
    case (k)
      0: return "OK";
      1: return "SEND OK";
      2: return "ERROR";
      3: return "FAIL";
      4: return "ALREADY CONNECTED";
      5: return "CLOSED";
      default: return "CONNECT";
    endcase
  endfunction

  // One received line: a reply word, a damaged word, a prompt, noise or nothing, then a terminator.
  task automatic add_line();
    string w;
    int kind, i, n;
    w = reply_word($urandom_range(0, 6));
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: add_text(w);
      3: begin
        // Word followed by a zero byte and trailing rubbish, sometimes past the buffer.
        add_text(w);
        add_byte(CH_NUL);
        n = $urandom_range(0, 20);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
      4: begin
        n = $urandom_range(1, w.len() - 1);
        for (i = 0; i < n; i++) add_byte(w[i]);
      end
      5: begin
        add_text(w);
        add_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      6: begin
        // Flip the case bit of one character; a space turns into a zero byte.
        n = $urandom_range(0, w.len() - 1);
        for (i = 0; i < w.len(); i++) add_byte((i == n) ? (w[i] ^ 8'h20) : w[i]);
      end
      7: begin
        n = $urandom_range(0, 2);
        repeat (n) add_byte(8'($urandom_range(8'h41, 8'h5A)));
        add_byte(CH_PROMPT);
      end
      8: begin
        n = $urandom_range(0, 24);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: add_byte(CH_CR);
      1: add_byte(CH_LF);
      default: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
    endcase
  endtask

  // One command: a start, then a few lines with ticks and stray requests between them.
  task automatic add_session();
    int n;
    add_req(OP_START, 8'($urandom_range(0, 255)));
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0, 1, 2: add_req(OP_TICK, 8'($urandom_range(0, 255)));
        3: add_req(OP_UNUSED, 8'($urandom_range(0, 255)));
        4: add_req(OP_START, 8'($urandom_range(0, 255)));
        default: ;
      endcase
      add_line();
    end
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ch.ready));
    cfg_valid <= 1'b0;
    if (idx == REG_MATCH_MODE) sh_mode = val[1:0];
    else sh_timeout = val;
  endtask

  // Waits until every queued request has gone and every outcome has arrived.
  task automatic wait_until_quiet();
    do @(posedge clk); while (reqs_to_send.size() != 0 || outcomes_owed.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus: a directed opening, then phases of random commands under changing settings.
  initial begin : stimulus
    int ph, target;
    logic [7:0] tmo;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests while not armed, the unused op, replies and a restarted timeout.
    add_req(OP_TICK, 8'hFF);
    add_byte("O");
    add_req(OP_UNUSED, 8'h00);
    add_req(OP_START, 8'hA5);
    add_req(OP_UNUSED, 8'h5A);
    add_text("OK");
    add_byte(CH_CR);
    add_req(OP_START, 8'h00);
    add_byte(CH_LF);
    add_text("SEND OK");
    add_byte(CH_LF);
    add_req(OP_START, 8'hFF);
    add_req(OP_TICK, 8'h00);
    add_req(OP_START, 8'h0F);
    add_req(OP_TICK, 8'hF0);
    add_req(OP_TICK, 8'h3C);
    wait_until_quiet();

    target = queued_count;
    for (ph = 0; ph < 12; ph++) begin
      case ((ph + ph / 4) % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 51; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 51; end
        default: begin send_gap_pct = 14; recv_stall_pct = 14; end
      endcase
      case (ph)
        0, 5, 10: tmo = 8'd255;
        1: tmo = 8'd0;
        2, 8: tmo = 8'd1;
        3: tmo = 8'd3;
        4, 9: tmo = 8'd2;
        7: tmo = 8'd4;
        default: tmo = 8'($urandom_range(1, 8));
      endcase
      write_reg(REG_MATCH_MODE, 8'(ph % 4));
      write_reg(REG_TIMEOUT, tmo);

      // The matcher may still be armed from the last phase, with a partial line kept.
      add_req(OP_TICK, 8'($urandom_range(0, 255)));
      add_byte("K");
      add_byte(CH_CR);
      target += 85;
      while (queued_count < target) add_session();
      add_req(OP_START, 8'($urandom_range(0, 255)));
      add_byte("O");
      wait_until_quiet();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
